[design/pli_pkg.sv]
package pli_pkg;

    localparam int unsigned MAX_KNOTS_DEF = 16;
    localparam int unsigned FRAC_BITS_DEF = 16;

    typedef enum logic [1:0] {
        REGION_INTERIOR = 2'd0,
        REGION_LOW      = 2'd1,
        REGION_HIGH     = 2'd2,
        REGION_EMPTY    = 2'd3
    } region_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } state_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Word that a knot cell hands to the next cell on each shift.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } knot_t;

endpackage

[design/pli_cell.sv]
module pli_cell
    import pli_pkg::*;
(
    input  logic  clk,
    input  logic  load,
    input  knot_t load_knot,
    input  logic  shift,
    input  knot_t prev_knot,
    output knot_t knot
);

    knot_t knot_reg;

    // Load a written knot, or take the neighbor's knot while rotating.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            knot_reg <= load_knot;
        end
        else if (shift)
        begin
            knot_reg <= prev_knot;
        end
    end

    assign knot = knot_reg;

endmodule

[design/piecewise_linear_interpolation_core.sv]
// Piecewise linear interpolation over a table of ascending knots (Q16.16).
// Channels: raise start with opcode and payload while busy is low; the item
// is taken at that edge. Opcode write stores knot_x/knot_y at knot_index and
// gives no result. Opcode query gives one result on interp_y and
// region_status, marked by done for exactly one cycle.
// knot_count is written through cfg_valid/cfg_ready/cfg_data while idle.
// Knots sit in a ring of cells; a query rotates the ring once, one cell a
// cycle, so head cell holds knot i in scan cycle i.
// A query scans all MAX_KNOTS cells, then for an interior point runs
// 32+FRAC_BITS restoring division steps, one multiply, one add and the
// output state. A clamped or empty query skips the arithmetic and goes
// from the scan straight to the output state. done rises in the first
// cycle with busy low; the next item may be taken at the edge that ends
// it. A write never raises busy, so writes can follow back to back. One
// query at a time. Reset clears knot_count and control; table contents
// are undefined until written. The receiver cannot stall: done is a
// one-cycle strobe.
module piecewise_linear_interpolation_core
    import pli_pkg::*;
#(
    parameter int unsigned MAX_KNOTS = MAX_KNOTS_DEF,
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               opcode,
    input  logic [3:0]         knot_index,
    input  logic signed [31:0] knot_x,
    input  logic signed [31:0] knot_y,
    input  logic signed [31:0] query_x,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [4:0]         cfg_data,
    output logic               done,
    output logic signed [31:0] interp_y,
    output logic [1:0]         region_status
);

    localparam int unsigned IW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int unsigned DW = 33 + FRAC_BITS;
    localparam int unsigned QW = 32 + FRAC_BITS;
    localparam int unsigned CW = $clog2(QW + 1);

    state_t state_reg, state_next;
    logic [4:0] count_reg;
    knot_t cells [MAX_KNOTS];
    logic shift;
    logic [IW:0] step_reg;
    logic [CW-1:0] div_cnt_reg;
    logic signed [32:0] qx_reg;
    logic [IW:0] n_eff;
    knot_t first_reg, prev_reg, last_reg;
    logic found_reg;
    logic signed [32:0] y0_reg, dy_reg;
    logic [32:0] w_reg;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] num_reg, quo_reg;
    logic signed [QW+34:0] prod_reg;
    logic zero_w_reg;
    logic signed [31:0] y_out_reg;
    region_t reg_out_reg;
    logic done_reg;
    knot_t head;
    knot_t last_knot;
    logic hit;
    logic clamp;
    logic [DW-1:0] rem_sh;
    logic signed [QW+34:0] fl;
    logic signed [QW+35:0] sum;

    assign n_eff = (count_reg > 5'(MAX_KNOTS)) ? (IW+1)'(MAX_KNOTS) : (IW+1)'(count_reg);
    assign head  = cells[0];
    assign shift = (state_reg == ST_SCAN);
    assign busy  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    // Build the ring: cell k takes from cell k+1, the last from the head.
    for (genvar k = 0; k < MAX_KNOTS; k++)
    begin : g_cell
        logic ld;
        assign ld = start && !busy && (opcode == OP_WRITE) &&
                    ({1'b0, knot_index} == 5'(k)) ;
        pli_cell u_cell (
            .clk       (clk),
            .load      (ld),
            .load_knot ({knot_x, knot_y}),
            .shift     (shift),
            .prev_knot (cells[(k + 1) % MAX_KNOTS]),
            .knot      (cells[k])
        );
    end

    // Interval hit at the current scan step: prev knot and head bound x.
    assign hit = !found_reg && (step_reg != '0) && (step_reg < n_eff) &&
                 (qx_reg >= $signed({prev_reg.x[31], prev_reg.x})) &&
                 (qx_reg <= $signed({head.x[31], head.x}));

    // Last valid knot: still at the head on the scan step of knot n_eff-1.
    assign last_knot = (step_reg == n_eff - 1'b1) ? head : last_reg;

    // Query clamps to an end of the table or the table is too short.
    assign clamp = (n_eff < (IW+1)'(2)) ||
                   (qx_reg <= $signed({first_reg.x[31], first_reg.x})) ||
                   (qx_reg >= $signed({last_knot.x[31], last_knot.x}));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && opcode == OP_QUERY)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (step_reg == (IW+1)'(MAX_KNOTS - 1))
                begin
                    state_next = (!clamp && (found_reg || hit)) ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:  state_next = (div_cnt_reg == CW'(QW - 1)) ? ST_MUL : ST_DIV;
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_DONE);
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    // Datapath: scan, divide, multiply, add.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                step_reg  <= '0;
                found_reg <= 1'b0;
                qx_reg    <= {query_x[31], query_x};
            end
            ST_SCAN:
            begin
                step_reg <= step_reg + 1'b1;
                prev_reg <= head;
                if (step_reg == '0)
                begin
                    first_reg <= head;
                end
                if (step_reg == n_eff - 1'b1)
                begin
                    last_reg <= head;
                end
                if (hit)
                begin
                    found_reg   <= 1'b1;
                    y0_reg      <= {prev_reg.y[31], prev_reg.y};
                    dy_reg      <= {head.y[31], head.y} - {prev_reg.y[31], prev_reg.y};
                    w_reg       <= 33'({head.x[31], head.x} - {prev_reg.x[31], prev_reg.x});
                    num_reg     <= QW'(33'(qx_reg - {prev_reg.x[31], prev_reg.x}))
                                   << FRAC_BITS;
                    zero_w_reg  <= (head.x == prev_reg.x);
                    rem_reg     <= '0;
                    div_cnt_reg <= '0;
                end
                if (step_reg == (IW+1)'(MAX_KNOTS - 1))
                begin
                    if (n_eff == '0)
                    begin
                        y_out_reg <= '0; reg_out_reg <= REGION_EMPTY;
                    end
                    else if (n_eff == (IW+1)'(1) ||
                             qx_reg <= $signed({first_reg.x[31], first_reg.x}))
                    begin
                        y_out_reg <= first_reg.y; reg_out_reg <= REGION_LOW;
                    end
                    else if (clamp || !(found_reg || hit))
                    begin
                        y_out_reg <= last_knot.y; reg_out_reg <= REGION_HIGH;
                    end
                    else
                    begin
                        reg_out_reg <= REGION_INTERIOR;
                    end
                end
            end
            ST_DIV:
            begin
                rem_reg     <= (rem_sh >= DW'(w_reg)) ? rem_sh - DW'(w_reg) : rem_sh;
                quo_reg     <= {quo_reg[QW-2:0], (rem_sh >= DW'(w_reg))};
                num_reg     <= num_reg << 1;
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            // Weight is at most one, so only its low FRAC_BITS+1 bits matter.
            ST_MUL: prod_reg <= $signed({1'b0, quo_reg[FRAC_BITS:0]}) * dy_reg;
            ST_ADD:
            begin
                if (!zero_w_reg)
                begin
                    y_out_reg <= (sum > 36'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                                 (sum < -36'sh80000000) ? -32'sh80000000 : 32'(sum);
                end
                else
                begin
                    y_out_reg <= 32'(y0_reg);
                end
            end
            default: ;
        endcase
    end

    assign rem_sh = {rem_reg[DW-2:0], num_reg[QW-1]};
    assign fl     = prod_reg >>> FRAC_BITS;
    assign sum    = (QW+36)'(y0_reg) + (QW+36)'(fl);

    assign done          = done_reg;
    assign interp_y      = y_out_reg;
    assign region_status = reg_out_reg;

    // Checks.
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy) else $error("config open while busy");

endmodule
